[rtl/nnpo_pkg.sv]
// ---------------------------------------------------------------------------
// nnpo_pkg
// Shared sizes and types for the nearest neighbor point ordering block.
// ---------------------------------------------------------------------------
package nnpo_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 24;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ENTRY_W = 3 * COORD_BITS;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int ACC_W   = SQ_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;

endpackage

[rtl/nearest_neighbor_point_ordering.sv]
// ---------------------------------------------------------------------------
// nearest_neighbor_point_ordering
// Greedy nearest neighbor walk over a loaded set of 3D points.
// ---------------------------------------------------------------------------
// Points are loaded one per transaction on the input channel: a transaction
// happens at a clock edge with start high and busy low. Loading a point
// without in_last leaves busy low. Points beyond capacity are dropped and
// flag overflow on every result of that set.
// The transaction carrying in_last closes the set; busy then stays high while
// the set is walked. The walk begins at point zero, or with cfg_start_leftmost
// set, at the first point of least x (found by a pre-scan of the stored points).
// Each result is shown for one cycle with out_valid; the receiver cannot
// stall, so results are simply dropped if not taken.
// For each emitted point the block reads it (S_LOAD) and emits it (S_EMIT),
// then, unless it was the last, scans all n stored entries: S_RD per index,
// and for each unvisited candidate S_DIF, S_MUL and S_ACC per axis and then
// S_CMP, since one subtractor, one 24x24 multiplier and one adder compute
// dx^2+dy^2+dz^2 one axis at a time.
// The configuration channel is always ready. Reset returns the block to an
// empty set with the walk starting at point zero; the stores are not cleared.
// ---------------------------------------------------------------------------
module nearest_neighbor_point_ordering (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  nnpo_pkg::coord_t       in_pos_x,
  input  nnpo_pkg::coord_t       in_pos_y,
  input  nnpo_pkg::coord_t       in_pos_z,
  input  logic                   in_last,
  output logic                   out_valid,
  output nnpo_pkg::idx_t         out_point_index,
  output nnpo_pkg::coord_t       out_x,
  output nnpo_pkg::coord_t       out_y,
  output nnpo_pkg::coord_t       out_z,
  output logic                   out_end_of_set,
  output logic                   out_overflow,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_start_leftmost
);

  import nnpo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LM_RD,
    S_LM_CMP,
    S_LOAD,
    S_EMIT,
    S_RD,
    S_DIF,
    S_MUL,
    S_ACC,
    S_CMP
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  start_lm_r;
  logic [MAX_POINTS-1:0] visited_r, visited_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  idx_t                  cur_r, cur_nxt;
  coord_t                cur_x_r, cur_x_nxt;
  coord_t                cur_y_r, cur_y_nxt;
  coord_t                cur_z_r, cur_z_nxt;
  coord_t                min_x_r, min_x_nxt;
  idx_t                  min_idx_r, min_idx_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [COORD_BITS-1:0] diff_r, diff_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ACC_W-1:0]      best_r, best_nxt;
  idx_t                  next_r, next_nxt;
  logic                  found_r, found_nxt;

  logic                  out_valid_r, out_valid_nxt;
  idx_t                  out_idx_r, out_idx_nxt;
  coord_t                out_x_r, out_x_nxt;
  coord_t                out_y_r, out_y_nxt;
  coord_t                out_z_r, out_z_nxt;
  logic                  out_eos_r, out_eos_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  wr_en;
  logic                  rd_en;
  idx_t                  rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  coord_t                rd_x, rd_y, rd_z;
  coord_t                sub_a, sub_b;
  logic signed [COORD_BITS:0] sub_d;

  nnpo_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_pos_z, in_pos_y, in_pos_x}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x = rd_data[COORD_BITS-1:0];
  assign rd_y = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_z = rd_data[3*COORD_BITS-1:2*COORD_BITS];

  // Shared subtractor: one axis of the current point against the candidate.
  always_comb begin
    case (k_r)
      2'd0: begin
        sub_a = cur_x_r;
        sub_b = rd_x;
      end
      2'd1: begin
        sub_a = cur_y_r;
        sub_b = rd_y;
      end
      default: begin
        sub_a = cur_z_r;
        sub_b = rd_z;
      end
    endcase
    sub_d = {sub_a[COORD_BITS-1], sub_a} - {sub_b[COORD_BITS-1], sub_b};
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    dropped_nxt  = dropped_r;
    visited_nxt  = visited_r;
    i_nxt        = i_r;
    emit_cnt_nxt = emit_cnt_r;
    cur_nxt      = cur_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cur_z_nxt    = cur_z_r;
    min_x_nxt    = min_x_r;
    min_idx_nxt  = min_idx_r;
    k_nxt        = k_r;
    diff_nxt     = diff_r;
    sq_nxt       = sq_r;
    acc_nxt      = acc_r;
    best_nxt     = best_r;
    next_nxt     = next_r;
    found_nxt    = found_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt  = out_idx_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_z_nxt    = out_z_r;
    out_eos_nxt  = out_eos_r;
    out_ovf_nxt  = out_ovf_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = i_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count_r < CNT_W'(MAX_POINTS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            emit_cnt_nxt = '0;
            i_nxt        = '0;
            cur_nxt      = '0;
            state_nxt    = start_lm_r ? S_LM_RD : S_LOAD;
          end
        end
      end

      S_LM_RD: begin
        if (i_r == count_r) begin
          cur_nxt   = min_idx_r;
          state_nxt = S_LOAD;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_LM_CMP;
        end
      end

      S_LM_CMP: begin
        // Strict compare keeps the first point of least x.
        if (i_r == '0 || rd_x < min_x_r) begin
          min_x_nxt   = rd_x;
          min_idx_nxt = i_r[IDX_W-1:0];
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_LM_RD;
      end

      S_LOAD: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        cur_x_nxt          = rd_x;
        cur_y_nxt          = rd_y;
        cur_z_nxt          = rd_z;
        out_valid_nxt      = 1'b1;
        out_idx_nxt        = cur_r;
        out_x_nxt          = rd_x;
        out_y_nxt          = rd_y;
        out_z_nxt          = rd_z;
        out_ovf_nxt        = dropped_r;
        out_eos_nxt        = (emit_cnt_r == count_r - CNT_W'(1));
        visited_nxt[cur_r] = 1'b1;
        emit_cnt_nxt       = emit_cnt_r + CNT_W'(1);
        if (emit_cnt_r == count_r - CNT_W'(1)) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          visited_nxt = '0;
          state_nxt   = S_IDLE;
        end else begin
          i_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        if (i_r == count_r) begin
          cur_nxt   = next_r;
          state_nxt = S_LOAD;
        end else if (visited_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          rd_en     = 1'b1;
          k_nxt     = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_DIF;
        end
      end

      S_DIF: begin
        diff_nxt  = sub_d[COORD_BITS] ? COORD_BITS'(-sub_d) : sub_d[COORD_BITS-1:0];
        state_nxt = S_MUL;
      end

      S_MUL: begin
        sq_nxt    = diff_r * diff_r;
        state_nxt = S_ACC;
      end

      S_ACC: begin
        acc_nxt = acc_r + ACC_W'(sq_r);
        if (k_r == 2'd2) begin
          state_nxt = S_CMP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DIF;
        end
      end

      S_CMP: begin
        // Strict compare leaves ties with the lowest index.
        if (!found_r || acc_r < best_r) begin
          best_nxt  = acc_r;
          next_nxt  = i_r[IDX_W-1:0];
          found_nxt = 1'b1;
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      visited_r   <= '0;
      start_lm_r  <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        start_lm_r <= cfg_start_leftmost;
      end
    end
    i_r        <= i_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    cur_r      <= cur_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    cur_z_r    <= cur_z_nxt;
    min_x_r    <= min_x_nxt;
    min_idx_r  <= min_idx_nxt;
    k_r        <= k_nxt;
    diff_r     <= diff_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    best_r     <= best_nxt;
    next_r     <= next_nxt;
    out_idx_r  <= out_idx_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_z_r    <= out_z_nxt;
    out_eos_r  <= out_eos_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_point_index = out_idx_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_z           = out_z_r;
  assign out_end_of_set  = out_eos_r;
  assign out_overflow    = out_ovf_r;

endmodule

[rtl/nnpo_ram.sv]
// ---------------------------------------------------------------------------
// nnpo_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module nnpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[verif/nnpo_tour_checker.sv]
// ---------------------------------------------------------------------------
// nnpo_tour_checker
// Watches the point, result and configuration channels of the nearest
// neighbor point ordering block. It keeps its own copy of the loaded set,
// works out the greedy walk when a set closes, and compares every emitted
// point field by field with the oldest stop still waiting.
// ---------------------------------------------------------------------------
module nnpo_tour_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  nnpo_pkg::coord_t in_pos_x,
  input  nnpo_pkg::coord_t in_pos_y,
  input  nnpo_pkg::coord_t in_pos_z,
  input  logic             in_last,
  input  logic             out_valid,
  input  nnpo_pkg::idx_t   out_point_index,
  input  nnpo_pkg::coord_t out_x,
  input  nnpo_pkg::coord_t out_y,
  input  nnpo_pkg::coord_t out_z,
  input  logic             out_end_of_set,
  input  logic             out_overflow,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_start_leftmost,
  output int               fail_count,
  output int               pending
);
  import nnpo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    idx_t   index;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   end_of_set;
    logic   overflow;
  } tour_stop_t;

  coord_t     set_x [MAX_POINTS];
  coord_t     set_y [MAX_POINTS];
  coord_t     set_z [MAX_POINTS];
  int         held_points = 0;
  logic       points_dropped = 1'b0;
  logic       leftmost_mode = 1'b0;
  tour_stop_t tour_q [$];
  int         mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Exact squared distance; three 25-bit differences squared fit easily in 64 bits.
  function automatic longint dist_sq(int a, int b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(set_x[a]) - longint'(set_x[b]);
    dy = longint'(set_y[a]) - longint'(set_y[b]);
    dz = longint'(set_z[a]) - longint'(set_z[b]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  task automatic plan_tour();
    logic       seen [MAX_POINTS];
    int         cur;
    int         nxt;
    longint     best;
    longint     d;
    logic       found;
    tour_stop_t stop;
    for (int i = 0; i < MAX_POINTS; i++) seen[i] = 1'b0;
    cur  = 0;
    nxt  = 0;
    best = 0;
    if (leftmost_mode) begin
      for (int i = 1; i < held_points; i++)
        if (set_x[i] < set_x[cur]) cur = i;
    end
    for (int k = 0; k < held_points; k++) begin
      seen[cur]       = 1'b1;
      stop.index      = idx_t'(cur);
      stop.x          = set_x[cur];
      stop.y          = set_y[cur];
      stop.z          = set_z[cur];
      stop.end_of_set = (k == held_points - 1);
      stop.overflow   = points_dropped;
      tour_q.push_back(stop);
      found = 1'b0;
      for (int i = 0; i < held_points; i++) begin
        if (!seen[i]) begin
          d = dist_sq(cur, i);
          // Strict less-than keeps the lowest index on a tie.
          if (!found || d < best) begin
            found = 1'b1;
            best  = d;
            nxt   = i;
          end
        end
      end
      if (!found) break;
      cur = nxt;
    end
    held_points    = 0;
    points_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    tour_stop_t want;
    if (!rst_n) begin
      held_points    = 0;
      points_dropped = 1'b0;
      leftmost_mode  = 1'b0;
      tour_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) leftmost_mode = cfg_start_leftmost;

      if (out_valid) begin
        if (tour_q.size() == 0) begin
          report_mismatch($sformatf("result for point %0d with nothing expected",
                                    out_point_index));
        end else begin
          want = tour_q.pop_front();
          if (out_point_index !== want.index)
            report_mismatch($sformatf("point_index got %0d expected %0d",
                                      out_point_index, want.index));
          if (out_x !== want.x)
            report_mismatch($sformatf("point %0d out_x got %0d expected %0d",
                                      want.index, out_x, want.x));
          if (out_y !== want.y)
            report_mismatch($sformatf("point %0d out_y got %0d expected %0d",
                                      want.index, out_y, want.y));
          if (out_z !== want.z)
            report_mismatch($sformatf("point %0d out_z got %0d expected %0d",
                                      want.index, out_z, want.z));
          if (out_end_of_set !== want.end_of_set)
            report_mismatch($sformatf("point %0d end_of_set got %b expected %b",
                                      want.index, out_end_of_set, want.end_of_set));
          if (out_overflow !== want.overflow)
            report_mismatch($sformatf("point %0d overflow got %b expected %b",
                                      want.index, out_overflow, want.overflow));
        end
      end

      if (start && !busy) begin
        if (held_points < MAX_POINTS) begin
          set_x[held_points] = in_pos_x;
          set_y[held_points] = in_pos_y;
          set_z[held_points] = in_pos_z;
          held_points++;
        end else begin
          points_dropped = 1'b1;
        end
        if (in_last) plan_tour();
      end
    end
    pending    <= tour_q.size();
    fail_count <= mismatches;
  end

endmodule

[verif/nearest_neighbor_point_ordering_tb.sv]
// ---------------------------------------------------------------------------
// nearest_neighbor_point_ordering_tb
// Loads point sets into the block and lets the tour checker verify each walk.
// A short directed part covers single points, extreme coordinates, distance
// ties and the leftmost start. The random part mixes small clustered sets,
// duplicate points and full or overflowing sets under both start modes, with
// random gaps on the input side.
// ---------------------------------------------------------------------------
module nearest_neighbor_point_ordering_tb;
  import nnpo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 2 * MAX_POINTS + 16;
  localparam int PHASE_ITEMS   = 110;
  localparam int TIME_LIMIT_NS = 20_000_000;

  localparam coord_t C_MAX = coord_t'(24'h7FFFFF);
  localparam coord_t C_MIN = coord_t'(24'h800000);

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_pos_x = '0;
  coord_t in_pos_y = '0;
  coord_t in_pos_z = '0;
  logic   in_last = 1'b0;
  logic   out_valid;
  idx_t   out_point_index;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   out_end_of_set;
  logic   out_overflow;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic   cfg_start_leftmost = 1'b0;
  int     fail_count;
  int     pending;

  int     items_sent = 0;
  logic   steady = 1'b0;

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  nearest_neighbor_point_ordering dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_point_index    (out_point_index),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_z              (out_z),
    .out_end_of_set     (out_end_of_set),
    .out_overflow       (out_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_start_leftmost (cfg_start_leftmost)
  );

  nnpo_tour_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_point_index    (out_point_index),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_z              (out_z),
    .out_end_of_set     (out_end_of_set),
    .out_overflow       (out_overflow),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_start_leftmost (cfg_start_leftmost),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Small clusters make distance ties common; the rest covers the full range.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      1, 2:    return coord_t'(int'($urandom_range(0, 15)) - 8);
      3, 4:    return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic push_point(coord_t x, coord_t y, coord_t z, logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_last  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every expected point has been emitted and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_mode(logic leftmost);
    cfg_valid          <= 1'b1;
    cfg_start_leftmost <= leftmost;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_set(int n);
    coord_t sx [128];
    coord_t sy [128];
    coord_t sz [128];
    int     j;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      sx[i] = rand_coord();
      sy[i] = rand_coord();
      sz[i] = rand_coord();
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        // Repeat an earlier point exactly, giving a zero-distance tie.
        j = $urandom_range(0, i - 1);
        sx[i] = sx[j];
        sy[i] = sy[j];
        sz[i] = sz[j];
      end else if (i > 0 && $urandom_range(0, 7) == 0) begin
        sx[i] = sx[$urandom_range(0, i - 1)];
      end
      push_point(sx[i], sy[i], sz[i], i == n - 1);
    end
  endtask

  initial begin
    int phase_end;
    int set_size;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-point sets at both coordinate extremes.
    push_point(C_MAX, C_MAX, C_MAX, 1'b1);
    push_point(C_MIN, C_MIN, C_MIN, 1'b1);
    // Largest possible distance between two points.
    push_point(C_MIN, C_MIN, C_MIN, 1'b0);
    push_point(C_MAX, C_MAX, C_MAX, 1'b1);
    // Three candidates at equal distance from the start; the lowest index wins.
    push_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(16), coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(-16), coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(0), coord_t'(16), coord_t'(0), 1'b1);
    drain();

    write_start_mode(1'b1);
    // Two points share the least x; the walk must start at the first of them.
    push_point(coord_t'(5), coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(-3), coord_t'(1), coord_t'(1), 1'b0);
    push_point(coord_t'(-3), coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(7), coord_t'(-2), coord_t'(9), 1'b1);
    // Least x sits on the closing point.
    push_point(C_MAX, coord_t'(0), coord_t'(0), 1'b0);
    push_point(coord_t'(0), C_MAX, C_MIN, 1'b0);
    push_point(C_MIN, coord_t'(0), coord_t'(0), 1'b1);
    // A lone point in leftmost mode.
    push_point(coord_t'(-1), C_MIN, C_MAX, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_start_mode(phase % 2 == 1);
      phase_end = items_sent + PHASE_ITEMS;
      // Full sets: one past capacity (closing point dropped), exactly full,
      // and several past capacity.
      case (phase)
        0: send_random_set(MAX_POINTS + 1);
        2: send_random_set(MAX_POINTS);
        3: send_random_set(MAX_POINTS + 4);
        default: ;
      endcase
      while (items_sent < phase_end) begin
        set_size = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24)
                                               : $urandom_range(1, 6);
        send_random_set(set_size);
        if ($urandom_range(0, 9) == 0) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
